### rtl/rrps_pkg.sv
// Shared types and constants of the round robin poll scheduler.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package rrps_pkg;

   // Default sizes
   localparam int MAX_LINKS_DEF  = 8;
   localparam int CLOCK_BITS_DEF = 28;

   // Fixed field widths
   localparam int KIND_W     = 2;
   localparam int CUR_W      = 3;
   localparam int MASK_W     = 8;
   localparam int LINK_OUT_W = 3;
   localparam int WHY_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int GAP_W      = 16;
   localparam int NUM_LINKS_W = 4;

   // Slot kinds
   localparam logic [KIND_W-1:0] KIND_DYNAMIC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OWNED    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_LINKS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_MASK    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POLL_GAP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DYN_POLL_GAP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DYNAMIC_POLL = 3'd4;

   // Register reset values
   localparam logic [GAP_W-1:0] MAX_POLL_GAP_RST = 16'd100;
   localparam logic [GAP_W-1:0] DYN_POLL_GAP_RST = 16'd40;

   // Grant reasons
   typedef enum logic [WHY_W-1:0] {
      WHY_NONE    = 3'd0,
      WHY_QOS     = 3'd1,
      WHY_DATA    = 3'd2,
      WHY_STARVE  = 3'd3,
      WHY_HIGH_RR = 3'd4,
      WHY_DYNAMIC = 3'd5,
      WHY_EVERY   = 3'd6
   } why_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_PREP_LOW,
      OP_PREP_HIGH,
      OP_PREP_START,
      OP_ADVANCE,
      OP_EMIT_NONE,
      OP_EMIT_QOS,
      OP_EMIT_SERVE,
      OP_EMIT_HIGH
   } op_type;

   typedef struct packed {
      op_type  op;
      why_type why;
   } ctrl_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic slot_reserved;
      logic slot_qos;
      logic hit_data;
      logic hit_starve;
      logic hit_high;
      logic hit_dyn;
      logic walk_last;
      logic reserve;
      logic dynamic;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/rrps_ifs.sv
// Valid/ready channel interfaces for poll requests and poll decisions.
// Depends on rrps_pkg for field widths.
`timescale 1ns / 1ps

interface rrps_req_if #(
   parameter int CLOCK_BITS = rrps_pkg::CLOCK_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic [rrps_pkg::KIND_W-1:0]       kind;
   logic [rrps_pkg::CUR_W-1:0]        cur_link;
   logic [CLOCK_BITS-1:0]             clock_req;
   logic [rrps_pkg::MASK_W-1:0]       has_data;
   logic [rrps_pkg::MASK_W-1:0]       suspended;
   logic                              poll_reserve;

   modport source (
      output valid, kind, cur_link, clock_req, has_data, suspended, poll_reserve,
      input  ready
   );
   modport sink (
      input  valid, kind, cur_link, clock_req, has_data, suspended, poll_reserve,
      output ready
   );
endinterface

interface rrps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               granted;
   logic [rrps_pkg::LINK_OUT_W-1:0]    link;
   logic [rrps_pkg::WHY_W-1:0]         why;

   modport source (
      output valid, granted, link, why,
      input  ready
   );
   modport sink (
      input  valid, granted, link, why,
      output ready
   );
endinterface

### rtl/rrps_ctrl.sv
// Controller of the poll scheduler: sequences the ring walks one link per cycle.
// Depends on rrps_pkg; drives commands into rrps_dp and reads its status.
`timescale 1ns / 1ps

module rrps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rrps_pkg::dp_status_type status,
   output rrps_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_LOW,
      S_HIGH,
      S_DYN,
      S_EVERY
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Pick next state and the datapath operation
   always_comb begin
      state_in = state_ff;
      cmd.op   = rrps_pkg::OP_NONE;
      cmd.why  = rrps_pkg::WHY_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = rrps_pkg::OP_CAPTURE;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.n_zero || status.slot_reserved) begin
               if (status.out_free) begin
                  cmd.op   = rrps_pkg::OP_EMIT_NONE;
                  state_in = S_IDLE;
               end
            end else if (status.slot_qos) begin
               if (status.out_free) begin
                  cmd.op   = rrps_pkg::OP_EMIT_QOS;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op   = rrps_pkg::OP_PREP_LOW;
               state_in = S_LOW;
            end
         end
         S_LOW: begin
            if (status.hit_data || status.hit_starve) begin
               if (status.out_free) begin
                  cmd.op   = rrps_pkg::OP_EMIT_SERVE;
                  cmd.why  = status.hit_data ? rrps_pkg::WHY_DATA : rrps_pkg::WHY_STARVE;
                  state_in = S_IDLE;
               end
            end else if (status.walk_last) begin
               if (status.reserve) begin
                  cmd.op   = rrps_pkg::OP_PREP_HIGH;
                  state_in = S_HIGH;
               end else begin
                  cmd.op   = rrps_pkg::OP_PREP_START;
                  state_in = status.dynamic ? S_DYN : S_EVERY;
               end
            end else begin
               cmd.op = rrps_pkg::OP_ADVANCE;
            end
         end
         S_HIGH: begin
            if (status.hit_high) begin
               if (status.out_free) begin
                  cmd.op   = rrps_pkg::OP_EMIT_HIGH;
                  cmd.why  = rrps_pkg::WHY_HIGH_RR;
                  state_in = S_IDLE;
               end
            end else if (status.walk_last) begin
               cmd.op   = rrps_pkg::OP_PREP_START;
               state_in = status.dynamic ? S_DYN : S_EVERY;
            end else begin
               cmd.op = rrps_pkg::OP_ADVANCE;
            end
         end
         S_DYN: begin
            if (status.hit_dyn) begin
               if (status.out_free) begin
                  cmd.op   = rrps_pkg::OP_EMIT_SERVE;
                  cmd.why  = rrps_pkg::WHY_DYNAMIC;
                  state_in = S_IDLE;
               end
            end else if (status.walk_last) begin
               if (status.out_free) begin
                  cmd.op   = rrps_pkg::OP_EMIT_NONE;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op = rrps_pkg::OP_ADVANCE;
            end
         end
         S_EVERY: begin
            if (status.out_free) begin
               cmd.op   = rrps_pkg::OP_EMIT_SERVE;
               cmd.why  = rrps_pkg::WHY_EVERY;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/rrps_dp.sv
// Datapath of the poll scheduler: registers, captured request, ring pointer,
// poll time stamps, age comparators and result register. Depends on rrps_pkg.
`timescale 1ns / 1ps

module rrps_dp #(
   parameter int MAX_LINKS  = rrps_pkg::MAX_LINKS_DEF,
   parameter int CLOCK_BITS = rrps_pkg::CLOCK_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [rrps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rrps_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request payload
   input  logic [rrps_pkg::KIND_W-1:0]         req_kind,
   input  logic [rrps_pkg::CUR_W-1:0]          req_cur_link,
   input  logic [CLOCK_BITS-1:0]               req_clock,
   input  logic [rrps_pkg::MASK_W-1:0]         req_has_data,
   input  logic [rrps_pkg::MASK_W-1:0]         req_suspended,
   input  logic                                req_poll_reserve,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_granted,
   output logic [rrps_pkg::LINK_OUT_W-1:0]     rsp_link,
   output rrps_pkg::why_type                   rsp_why,
   // control
   input  rrps_pkg::ctrl_cmd_type              cmd,
   output rrps_pkg::dp_status_type             status
);

   localparam int LW = $clog2(MAX_LINKS);
   localparam int NW = $clog2(MAX_LINKS + 1);

   // Mask bit of a link; links past the mask width read as clear
   function automatic logic mask_bit(input logic [rrps_pkg::MASK_W-1:0] m,
                                     input logic [LW-1:0] i);
      return (32'(i) < rrps_pkg::MASK_W) && m[3'(i)];
   endfunction

   // Next link in a ring of n links
   function automatic logic [LW-1:0] ring_next(input logic [LW-1:0] i,
                                               input logic [NW-1:0] n);
      if (32'(i) + 32'd1 == 32'(n)) begin
         return '0;
      end
      return LW'(32'(i) + 32'd1);
   endfunction

   // Configuration registers
   logic [rrps_pkg::NUM_LINKS_W-1:0] num_links_ff, num_links_in;
   logic [rrps_pkg::MASK_W-1:0]      high_mask_ff, high_mask_in;
   logic [rrps_pkg::GAP_W-1:0]       max_gap_ff, max_gap_in;
   logic [rrps_pkg::GAP_W-1:0]       dyn_gap_ff, dyn_gap_in;
   logic                             dyn_en_ff, dyn_en_in;

   // Captured transaction
   logic [rrps_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [rrps_pkg::CUR_W-1:0]       cur_ff, cur_in;
   logic [CLOCK_BITS-1:0]            clk_ff, clk_in;
   logic [rrps_pkg::MASK_W-1:0]      data_ff, data_in;
   logic [rrps_pkg::MASK_W-1:0]      susp_ff, susp_in;
   logic                             resv_ff, resv_in;

   // Scheduler state and walk registers
   logic [LW-1:0]                    last_link_ff, last_link_in;
   logic [LW-1:0]                    last_high_ff, last_high_in;
   logic [CLOCK_BITS-1:0]            poll_time_ff [MAX_LINKS];
   logic [CLOCK_BITS-1:0]            poll_time_in [MAX_LINKS];
   logic [LW-1:0]                    ptr_ff, ptr_in;
   logic [LW-1:0]                    cnt_ff, cnt_in;
   logic [LW-1:0]                    start_ff, start_in;

   // Result register
   logic                             out_valid_ff, out_valid_in;
   logic                             out_granted_ff, out_granted_in;
   logic [rrps_pkg::LINK_OUT_W-1:0]  out_link_ff, out_link_in;
   rrps_pkg::why_type                out_why_ff, out_why_in;

   // Derived values
   logic [NW-1:0]                    n_links;
   logic [LW-1:0]                    last_fix;
   logic [LW-1:0]                    high_fix;
   logic [CLOCK_BITS-1:0]            diff;
   logic [CLOCK_BITS-1:0]            age;
   logic                             high_at_ptr;
   logic                             data_at_ptr;

   // Clamp ring size
   assign n_links = (32'(num_links_ff) > MAX_LINKS) ? NW'(MAX_LINKS) : NW'(num_links_ff);

   // Reset stale last-served links
   assign last_fix = (32'(last_link_ff) >= 32'(n_links)) ? '0 : last_link_ff;
   assign high_fix = (32'(last_high_ff) >= 32'(n_links)) ? '0 : last_high_ff;

   // Poll age in slots of the link under the pointer
   assign diff = clk_ff - poll_time_ff[ptr_ff];
   assign age  = {1'b0, diff[CLOCK_BITS-1:1]};

   assign high_at_ptr = mask_bit(high_mask_ff, ptr_ff);
   assign data_at_ptr = mask_bit(data_ff, ptr_ff);

   // Status toward the controller
   always_comb begin
      status.n_zero        = (n_links == '0);
      status.slot_reserved = (kind_ff == rrps_pkg::KIND_RESERVED)
                          || (kind_ff == rrps_pkg::KIND_UNUSED);
      status.slot_qos      = (kind_ff == rrps_pkg::KIND_OWNED)
                          && (32'(cur_ff) < 32'(n_links)) && high_mask_ff[cur_ff];
      status.hit_data      = !high_at_ptr && data_at_ptr;
      status.hit_starve    = !high_at_ptr && (age >= CLOCK_BITS'(max_gap_ff));
      status.hit_high      = high_at_ptr && data_at_ptr;
      status.hit_dyn       = (age >= CLOCK_BITS'(dyn_gap_ff));
      status.walk_last     = (32'(cnt_ff) + 32'd1 == 32'(n_links));
      status.reserve       = resv_ff;
      status.dynamic       = dyn_en_ff;
      status.out_free      = !out_valid_ff || rsp_ready;
   end

   // Configuration writes
   always_comb begin
      num_links_in = num_links_ff;
      high_mask_in = high_mask_ff;
      max_gap_in   = max_gap_ff;
      dyn_gap_in   = dyn_gap_ff;
      dyn_en_in    = dyn_en_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rrps_pkg::CSR_NUM_LINKS:    num_links_in = csr_wdata[rrps_pkg::NUM_LINKS_W-1:0];
            rrps_pkg::CSR_HIGH_MASK:    high_mask_in = csr_wdata[rrps_pkg::MASK_W-1:0];
            rrps_pkg::CSR_MAX_POLL_GAP: max_gap_in   = csr_wdata;
            rrps_pkg::CSR_DYN_POLL_GAP: dyn_gap_in   = csr_wdata;
            rrps_pkg::CSR_DYNAMIC_POLL: dyn_en_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Execute the controller's operation
   always_comb begin
      kind_in        = kind_ff;
      cur_in         = cur_ff;
      clk_in         = clk_ff;
      data_in        = data_ff;
      susp_in        = susp_ff;
      resv_in        = resv_ff;
      last_link_in   = last_link_ff;
      last_high_in   = last_high_ff;
      poll_time_in   = poll_time_ff;
      ptr_in         = ptr_ff;
      cnt_in         = cnt_ff;
      start_in       = start_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_granted_in = out_granted_ff;
      out_link_in    = out_link_ff;
      out_why_in     = out_why_ff;
      unique case (cmd.op)
         rrps_pkg::OP_NONE: ;
         rrps_pkg::OP_CAPTURE: begin
            kind_in = req_kind;
            cur_in  = req_cur_link;
            clk_in  = req_clock;
            data_in = req_has_data;
            susp_in = req_suspended;
            resv_in = req_poll_reserve;
         end
         rrps_pkg::OP_PREP_LOW: begin
            last_link_in = last_fix;
            if (32'(last_link_ff) >= 32'(n_links)) begin
               last_high_in = '0;
            end
            start_in = mask_bit(susp_ff, last_fix) ? '0 : ring_next(last_fix, n_links);
            ptr_in   = mask_bit(susp_ff, last_fix) ? '0 : ring_next(last_fix, n_links);
            cnt_in   = '0;
         end
         rrps_pkg::OP_PREP_HIGH: begin
            last_high_in = high_fix;
            ptr_in = mask_bit(susp_ff, high_fix) ? '0 : ring_next(high_fix, n_links);
            cnt_in = '0;
         end
         rrps_pkg::OP_PREP_START: begin
            ptr_in = start_ff;
            cnt_in = '0;
         end
         rrps_pkg::OP_ADVANCE: begin
            ptr_in = ring_next(ptr_ff, n_links);
            cnt_in = cnt_ff + 1'b1;
         end
         rrps_pkg::OP_EMIT_NONE: begin
            out_valid_in   = 1'b1;
            out_granted_in = 1'b0;
            out_link_in    = '0;
            out_why_in     = rrps_pkg::WHY_NONE;
         end
         rrps_pkg::OP_EMIT_QOS: begin
            out_valid_in   = 1'b1;
            out_granted_in = 1'b1;
            out_link_in    = cur_ff;
            out_why_in     = rrps_pkg::WHY_QOS;
         end
         rrps_pkg::OP_EMIT_SERVE: begin
            last_link_in         = ptr_ff;
            poll_time_in[ptr_ff] = clk_ff;
            out_valid_in         = 1'b1;
            out_granted_in       = 1'b1;
            out_link_in          = rrps_pkg::LINK_OUT_W'(ptr_ff);
            out_why_in           = cmd.why;
         end
         rrps_pkg::OP_EMIT_HIGH: begin
            last_high_in   = ptr_ff;
            out_valid_in   = 1'b1;
            out_granted_in = 1'b1;
            out_link_in    = rrps_pkg::LINK_OUT_W'(ptr_ff);
            out_why_in     = rrps_pkg::WHY_HIGH_RR;
         end
         default: ;
      endcase
   end

   // Control and scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         num_links_ff <= '0;
         high_mask_ff <= '0;
         max_gap_ff   <= rrps_pkg::MAX_POLL_GAP_RST;
         dyn_gap_ff   <= rrps_pkg::DYN_POLL_GAP_RST;
         dyn_en_ff    <= 1'b0;
         last_link_ff <= '0;
         last_high_ff <= '0;
         for (int i = 0; i < MAX_LINKS; i++) begin
            poll_time_ff[i] <= '0;
         end
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         start_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         num_links_ff <= num_links_in;
         high_mask_ff <= high_mask_in;
         max_gap_ff   <= max_gap_in;
         dyn_gap_ff   <= dyn_gap_in;
         dyn_en_ff    <= dyn_en_in;
         last_link_ff <= last_link_in;
         last_high_ff <= last_high_in;
         poll_time_ff <= poll_time_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      cur_ff         <= cur_in;
      clk_ff         <= clk_in;
      data_ff        <= data_in;
      susp_ff        <= susp_in;
      resv_ff        <= resv_in;
      out_granted_ff <= out_granted_in;
      out_link_ff    <= out_link_in;
      out_why_ff     <= out_why_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_granted = out_granted_ff;
   assign rsp_link    = out_link_ff;
   assign rsp_why     = out_why_ff;

endmodule

### rtl/round_robin_poll_scheduler.sv
// Round robin poll scheduler, top level: one poll decision per request transaction.
// Decisions: unconfigured, reserved, unused and owned high-class slots are settled in the check
// state, all others by the ring walks, which test one link per cycle using a single poll age.
// One transaction at a time: a new request is accepted only when idle. A waiting result does
// not block acceptance of the next, but that decision waits until the result is taken.
// Reset (synchronous): registers to defaults, last-served links and poll stamps to zero.
`timescale 1ns / 1ps

module round_robin_poll_scheduler #(
   parameter int MAX_LINKS  = rrps_pkg::MAX_LINKS_DEF,
   parameter int CLOCK_BITS = rrps_pkg::CLOCK_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   rrps_req_if.sink                         req_bus,
   rrps_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [rrps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rrps_pkg::ctrl_cmd_type  cmd;
   rrps_pkg::dp_status_type status;
   rrps_pkg::why_type       why;

   // Sequence the walks
   rrps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold state and evaluate links
   rrps_dp #(
      .MAX_LINKS  (MAX_LINKS),
      .CLOCK_BITS (CLOCK_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_bus.kind),
      .req_cur_link     (req_bus.cur_link),
      .req_clock        (req_bus.clock_req),
      .req_has_data     (req_bus.has_data),
      .req_suspended    (req_bus.suspended),
      .req_poll_reserve (req_bus.poll_reserve),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_granted      (rsp_bus.granted),
      .rsp_link         (rsp_bus.link),
      .rsp_why          (why),
      .cmd              (cmd),
      .status           (status)
   );

   assign rsp_bus.why = why;

endmodule

### sim/testbench.sv
// Self-checking bench for round_robin_poll_scheduler: directed slots, then random phases.
// Depends on rtl/rrps_pkg.sv, rtl/rrps_ifs.sv and the scheduler RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int CLK_W       = rrps_pkg::CLOCK_BITS_DEF;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      logic [rrps_pkg::KIND_W-1:0] kind;
      logic [rrps_pkg::CUR_W-1:0]  cur_link;
      logic [CLK_W-1:0]            clock_req;
      logic [rrps_pkg::MASK_W-1:0] has_data;
      logic [rrps_pkg::MASK_W-1:0] suspended;
      logic                        poll_reserve;
   } poll_req_type;

   typedef struct packed {
      logic                            granted;
      logic [rrps_pkg::LINK_OUT_W-1:0] link;
      rrps_pkg::why_type               why;
   } poll_decision_type;

   // Poll decision predictor with its own copy of the registers and ring state
   class poll_scoreboard;
      bit [rrps_pkg::NUM_LINKS_W-1:0] num_links;
      bit [rrps_pkg::MASK_W-1:0]      high_mask;
      bit [rrps_pkg::GAP_W-1:0]       max_gap;
      bit [rrps_pkg::GAP_W-1:0]       dyn_gap;
      bit                             dyn_mode;
      bit [rrps_pkg::CUR_W-1:0]       last_link;
      bit [rrps_pkg::CUR_W-1:0]       last_high;
      bit [CLK_W-1:0]                 poll_stamp [rrps_pkg::MAX_LINKS_DEF];
      poll_decision_type              pending [$];
      int unsigned                    failures;

      function new();
         num_links = '0;
         high_mask = '0;
         max_gap   = rrps_pkg::MAX_POLL_GAP_RST;
         dyn_gap   = rrps_pkg::DYN_POLL_GAP_RST;
         dyn_mode  = 1'b0;
         last_link = '0;
         last_high = '0;
         foreach (poll_stamp[i]) poll_stamp[i] = '0;
         failures  = 0;
      endfunction

      function void write_reg(logic [rrps_pkg::CSR_IDX_W-1:0] idx,
                              logic [rrps_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            rrps_pkg::CSR_NUM_LINKS:    num_links = val[rrps_pkg::NUM_LINKS_W-1:0];
            rrps_pkg::CSR_HIGH_MASK:    high_mask = val[rrps_pkg::MASK_W-1:0];
            rrps_pkg::CSR_MAX_POLL_GAP: max_gap   = val;
            rrps_pkg::CSR_DYN_POLL_GAP: dyn_gap   = val;
            rrps_pkg::CSR_DYNAMIC_POLL: dyn_mode  = val[0];
            default: ;
         endcase
      endfunction

      // Age in slots: wrapped half-slot difference, halved
      function bit [CLK_W-2:0] slot_age(int l, bit [CLK_W-1:0] clk);
         bit [CLK_W-1:0] diff;
         diff = clk - poll_stamp[l];
         return diff[CLK_W-1:1];
      endfunction

      function poll_decision_type serve(int l, bit [CLK_W-1:0] clk, rrps_pkg::why_type w);
         poll_decision_type d;
         last_link     = rrps_pkg::CUR_W'(l);
         poll_stamp[l] = clk;
         d.granted = 1'b1;
         d.link    = rrps_pkg::LINK_OUT_W'(l);
         d.why     = w;
         return d;
      endfunction

      function poll_decision_type decide_poll(poll_req_type r);
         poll_decision_type d;
         int n, start, l;
         d.granted = 1'b0;
         d.link    = '0;
         d.why     = rrps_pkg::WHY_NONE;
         n = (num_links > rrps_pkg::MAX_LINKS_DEF) ? rrps_pkg::MAX_LINKS_DEF
                                                   : int'(num_links);
         if (n == 0) return d;
         if (r.kind == rrps_pkg::KIND_RESERVED || r.kind == rrps_pkg::KIND_UNUSED) return d;
         if (r.kind == rrps_pkg::KIND_OWNED && r.cur_link < n && high_mask[r.cur_link]) begin
            d.granted = 1'b1;
            d.link    = r.cur_link;
            d.why     = rrps_pkg::WHY_QOS;
            return d;
         end
         // Clear stale ring pointers
         if (last_link >= n) begin
            last_link = '0;
            last_high = '0;
         end
         start = r.suspended[last_link] ? 0 : (int'(last_link) + 1) % n;
         // Walk non-high links: data first, then starvation guard
         l = start;
         for (int i = 0; i < n; i++) begin
            if (!high_mask[l]) begin
               if (r.has_data[l]) return serve(l, r.clock_req, rrps_pkg::WHY_DATA);
               if (slot_age(l, r.clock_req) >= max_gap)
                  return serve(l, r.clock_req, rrps_pkg::WHY_STARVE);
            end
            l = (l + 1) % n;
         end
         // Round robin over high-class links with data
         if (r.poll_reserve) begin
            if (last_high >= n) last_high = '0;
            l = r.suspended[last_high] ? 0 : (int'(last_high) + 1) % n;
            for (int i = 0; i < n; i++) begin
               if (high_mask[l] && r.has_data[l]) begin
                  last_high = rrps_pkg::CUR_W'(l);
                  d.granted = 1'b1;
                  d.link    = rrps_pkg::LINK_OUT_W'(l);
                  d.why     = rrps_pkg::WHY_HIGH_RR;
                  return d;
               end
               l = (l + 1) % n;
            end
         end
         if (dyn_mode) begin
            l = start;
            for (int i = 0; i < n; i++) begin
               if (slot_age(l, r.clock_req) >= dyn_gap)
                  return serve(l, r.clock_req, rrps_pkg::WHY_DYNAMIC);
               l = (l + 1) % n;
            end
            return d;
         end
         return serve(start, r.clock_req, rrps_pkg::WHY_EVERY);
      endfunction

      function void note_request(poll_req_type r);
         pending.push_back(decide_poll(r));
      endfunction

      function void check_decision(poll_decision_type got);
         poll_decision_type want;
         if (pending.size() == 0) begin
            $error("decision with no request outstanding: granted %0d link %0d why %0d",
                   got.granted, got.link, got.why);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (got.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, got.granted);
            failures++;
         end
         if (got.link !== want.link) begin
            $error("link: expected %0d, got %0d", want.link, got.link);
            failures++;
         end
         if (got.why !== want.why) begin
            $error("why: expected %0d, got %0d", want.why, got.why);
            failures++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [rrps_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rrps_pkg::CSR_DATA_W-1:0] csr_wdata;

   rrps_req_if #(.CLOCK_BITS(CLK_W)) req_bus ();
   rrps_rsp_if                       rsp_bus ();

   poll_scoreboard sb = new();

   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   bit               hold_request;
   int unsigned      hold_count;
   logic [CLK_W-1:0] slot_clock;

   round_robin_poll_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Generate a 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Drive the receiver: random stalls, or a long hold-off when requested
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && hold_count < HOLD_CYCLES) begin
            rsp_bus.ready = 1'b0;
            hold_count++;
         end else begin
            if (hold_count >= HOLD_CYCLES) begin
               hold_request = 1'b0;
               hold_count   = 0;
            end
            rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic poll_req_type make_req(logic [rrps_pkg::KIND_W-1:0] kind,
                                             logic [rrps_pkg::CUR_W-1:0] cur,
                                             logic [CLK_W-1:0] clk,
                                             logic [rrps_pkg::MASK_W-1:0] data,
                                             logic [rrps_pkg::MASK_W-1:0] susp,
                                             logic reserve);
      poll_req_type r;
      r.kind         = kind;
      r.cur_link     = cur;
      r.clock_req    = clk;
      r.has_data     = data;
      r.suspended    = susp;
      r.poll_reserve = reserve;
      return r;
   endfunction

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(make_req(req_bus.kind, req_bus.cur_link, req_bus.clock_req,
                                     req_bus.has_data, req_bus.suspended,
                                     req_bus.poll_reserve));
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_decision('{granted: rsp_bus.granted, link: rsp_bus.link,
                                why: rrps_pkg::why_type'(rsp_bus.why)});
      end
   end

   // Offer one request transaction, with random idle cycles ahead of it
   task automatic send_request(poll_req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.kind         = r.kind;
      req_bus.cur_link     = r.cur_link;
      req_bus.clock_req    = r.clock_req;
      req_bus.has_data     = r.has_data;
      req_bus.suspended    = r.suspended;
      req_bus.poll_reserve = r.poll_reserve;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and hold until every predicted decision has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [rrps_pkg::CSR_IDX_W-1:0] idx,
                            logic [rrps_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_reg(idx, val);
   endtask

   // Reconfigure only once the block is idle
   task automatic write_config(int links, int hmask, int maxg, int dyng, int dmode);
      wait_drained();
      repeat (30) @(negedge clock);
      write_reg(rrps_pkg::CSR_NUM_LINKS, rrps_pkg::CSR_DATA_W'(links));
      write_reg(rrps_pkg::CSR_HIGH_MASK, rrps_pkg::CSR_DATA_W'(hmask));
      write_reg(rrps_pkg::CSR_MAX_POLL_GAP, rrps_pkg::CSR_DATA_W'(maxg));
      write_reg(rrps_pkg::CSR_DYN_POLL_GAP, rrps_pkg::CSR_DATA_W'(dyng));
      write_reg(rrps_pkg::CSR_DYNAMIC_POLL, rrps_pkg::CSR_DATA_W'(dmode));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Random slots: mostly an advancing clock, some jumps and wraps
   task automatic run_phase(int count, int send_pct, int stall_pct, bit pressure);
      int pick;
      logic [rrps_pkg::KIND_W-1:0] kind;
      logic [rrps_pkg::MASK_W-1:0] data;
      logic [rrps_pkg::MASK_W-1:0] susp;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (int k = 0; k < count; k++) begin
         if (pressure && k == 30) hold_request = 1'b1;
         if (pressure && k == 60) wait_drained();
         pick = $urandom_range(99);
         if (pick < 88)      slot_clock = slot_clock + CLK_W'($urandom_range(1, 6));
         else if (pick < 94) slot_clock = CLK_W'($urandom);
         else                slot_clock = {CLK_W{1'b1}} - CLK_W'($urandom_range(0, 8));
         pick = $urandom_range(99);
         if (pick < 55)      kind = rrps_pkg::KIND_DYNAMIC;
         else if (pick < 85) kind = rrps_pkg::KIND_OWNED;
         else if (pick < 93) kind = rrps_pkg::KIND_RESERVED;
         else                kind = rrps_pkg::KIND_UNUSED;
         pick = $urandom_range(99);
         if (pick < 35)      data = '0;
         else if (pick < 75) data = rrps_pkg::MASK_W'($urandom & $urandom & $urandom);
         else                data = rrps_pkg::MASK_W'($urandom);
         susp = ($urandom_range(99) < 60) ? '0 : rrps_pkg::MASK_W'($urandom & $urandom);
         send_request(make_req(kind, rrps_pkg::CUR_W'($urandom_range(7)), slot_clock,
                               data, susp, 1'($urandom_range(1))));
      end
   endtask

   // Give up after a generous fixed time
   initial begin
      #10_000_000;
      $display("round_robin_poll_scheduler verification failed");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.kind         = '0;
      req_bus.cur_link     = '0;
      req_bus.clock_req    = '0;
      req_bus.has_data     = '0;
      req_bus.suspended    = '0;
      req_bus.poll_reserve = 1'b0;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      hold_request         = 1'b0;
      hold_count           = 0;
      slot_clock           = CLK_W'($urandom);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Not initialised: no grants at all
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 10, 8'hFF, 8'h00, 1'b1));
      send_request(make_req(rrps_pkg::KIND_OWNED, 3, 12, 8'h00, 8'h00, 1'b0));

      // Four links, link 2 high class: every grant reason but dynamic in turn
      write_config(4, 8'h04, 100, 40, 0);
      send_request(make_req(rrps_pkg::KIND_RESERVED, 0, 1000, 8'hFF, 8'h00, 1'b1));
      send_request(make_req(rrps_pkg::KIND_UNUSED, 2, 1002, 8'hFF, 8'h00, 1'b0));
      send_request(make_req(rrps_pkg::KIND_OWNED, 2, 1004, 8'h00, 8'h00, 1'b0));
      send_request(make_req(rrps_pkg::KIND_OWNED, 6, 1006, 8'h02, 8'h00, 1'b0));
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 1008, 8'h08, 8'h00, 1'b0));
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 1010, 8'h00, 8'h00, 1'b0));
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 1012, 8'h04, 8'h00, 1'b1));
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 1014, 8'h00, 8'h01, 1'b0));
      send_request(make_req(rrps_pkg::KIND_OWNED, 7, {CLK_W{1'b1}}, 8'hFF, 8'hFF, 1'b1));

      // Two links, dynamic ageing: serve both, find nothing, then age one
      write_config(2, 8'h00, 100, 40, 1);
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 2000, 8'h02, 8'h00, 1'b0));
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 2002, 8'h01, 8'h00, 1'b0));
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 2004, 8'h00, 8'h00, 1'b1));
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 2090, 8'h00, 8'h00, 1'b0));

      // Shrink the ring under the last-served link
      write_config(1, 8'h00, 100, 40, 0);
      send_request(make_req(rrps_pkg::KIND_DYNAMIC, 0, 2100, 8'h00, 8'h00, 1'b0));

      write_config(8, $urandom_range(255), 20, 10, 0);
      run_phase(90, 0, 0, 1'b1);
      write_config(3, $urandom_range(255), 0, 65535, 1);
      run_phase(85, 83, 0, 1'b0);
      write_config(8, 8'hFF, 65535, 0, 1);
      run_phase(85, 0, 83, 1'b0);
      write_config(15, 8'h00, 12, 6, 1);
      run_phase(85, 20, 20, 1'b0);
      write_config(1, $urandom_range(255), 8, 4, 0);
      run_phase(80, 0, 0, 1'b0);
      write_config(5, $urandom_range(255), $urandom_range(4, 30), $urandom_range(2, 20), 1);
      run_phase(90, 83, 0, 1'b0);
      write_config(2, 8'h02, 65535, 65535, 1);
      run_phase(80, 0, 83, 1'b0);
      write_config(8, $urandom_range(255), 30, 15, 1);
      run_phase(90, 20, 20, 1'b0);

      // Drain, then watch for stray decisions
      wait_drained();
      recv_stall_pct = 0;
      repeat (40) @(negedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("round_robin_poll_scheduler verification clean");
      end else begin
         $display("round_robin_poll_scheduler verification failed");
      end
      $finish;
   end

endmodule
